>>> src/sfw_pkg.sv
// ----------------------------------------------------------------------------
// sfw_pkg: shared types and constants of the soft-clip/foldback waveshaper
// Sample formats, fixed-point constants, register indexes and the clamp
// limit lookup shared by the channel interfaces and the datapath.
// ----------------------------------------------------------------------------
package sfw_pkg;

   // Sample formats
   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = 18;
   localparam int OUT_BITS    = FRAC_BITS + 2;
   localparam int ONE_Q       = 1 << FRAC_BITS;
   localparam int HALF_ONE_Q  = 1 << (FRAC_BITS - 1);

   // Datapath widths
   localparam int WIDE_BITS   = SAMPLE_BITS + 1;  // sign-extended sample
   localparam int LIM_BITS    = 23;               // clamp level, up to 12.0
   localparam int V_BITS      = FRAC_BITS + 2;    // folded value, +-1.5
   localparam int MAG_BITS    = V_BITS - 1;       // magnitude of folded value
   localparam int SQ_BITS     = 2 * MAG_BITS;     // v*v
   localparam int V2_BITS     = SQ_BITS - FRAC_BITS;
   localparam int PROD_BITS   = MAG_BITS + V2_BITS;
   localparam int NSUM_BITS   = PROD_BITS + 2;    // 4*|v|*v2 plus rounding
   localparam int NUM_BITS    = NSUM_BITS - FRAC_BITS;
   localparam int RECIP_BITS  = 23;
   localparam int RECIP_SHIFT = 27;
   localparam int RP_BITS     = NUM_BITS + RECIP_BITS;
   localparam int Q_BITS      = RP_BITS - RECIP_SHIFT;
   localparam int Y_BITS      = V_BITS + 1;

   // Configuration port
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 4;

   typedef logic [CSR_IDX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_FOLD_ENABLE   = 1'b0;
   localparam csr_index_type CSR_CLIP_MULTIPLE = 1'b1;

   localparam logic [CSR_DATA_BITS-1:0] CLIP_MULT_MIN   = 4'd1;
   localparam logic [CSR_DATA_BITS-1:0] CLIP_MULT_MAX   = 4'd8;
   localparam logic [CSR_DATA_BITS-1:0] CLIP_MULT_RESET = 4'd1;

   // Payload and internal types
   typedef logic signed [SAMPLE_BITS-1:0] sample_in_type;
   typedef logic signed [OUT_BITS-1:0]    sample_out_type;
   typedef logic signed [WIDE_BITS-1:0]   wide_type;
   typedef logic        [LIM_BITS-1:0]    lim_type;
   typedef logic signed [V_BITS-1:0]      v_type;
   typedef logic        [MAG_BITS-1:0]    mag_type;
   typedef logic        [SQ_BITS-1:0]     sq_type;
   typedef logic        [V2_BITS-1:0]     v2_type;
   typedef logic        [PROD_BITS-1:0]   prod_type;
   typedef logic        [NSUM_BITS-1:0]   nsum_type;
   typedef logic        [NUM_BITS-1:0]    num_type;
   typedef logic        [RP_BITS-1:0]     rp_type;
   typedef logic        [Q_BITS-1:0]      q_type;
   typedef logic signed [Y_BITS-1:0]      y_type;

   // Clamp level unit: 1.5
   localparam lim_type LIM_UNIT = LIM_BITS'(3 * HALF_ONE_Q);

   // Fold constants: bias to a positive range, period multiples, tail offsets
   localparam wide_type FOLD_BIAS = WIDE_BITS'(15 * ONE_Q);
   localparam wide_type FOLD_P1   = WIDE_BITS'(6 * ONE_Q);
   localparam wide_type FOLD_P2   = WIDE_BITS'(12 * ONE_Q);
   localparam wide_type FOLD_P3   = WIDE_BITS'(18 * ONE_Q);
   localparam wide_type FOLD_P4   = WIDE_BITS'(24 * ONE_Q);
   localparam wide_type TAIL_A    = WIDE_BITS'(9 * HALF_ONE_Q);
   localparam wide_type TAIL_B    = WIDE_BITS'(3 * ONE_Q);
   localparam wide_type TAIL_C    = WIDE_BITS'(3 * HALF_ONE_Q);

   // Cubic constants
   localparam v_type    V_LIMIT    = V_BITS'(3 * HALF_ONE_Q);
   localparam sq_type   ROUND_HALF = SQ_BITS'(HALF_ONE_Q);
   localparam nsum_type DIV_HALF   = NSUM_BITS'(27 * HALF_ONE_Q);
   // ceil(2^27 / 27): exact floor(n / 27) for n below 2^22
   localparam logic [RECIP_BITS-1:0] RECIP_27 = RECIP_BITS'(4971027);
   localparam y_type    Y_ONE      = Y_BITS'(ONE_Q);

   // Foldback clamp level: 1.5 times the multiple, multiple held to 1..8
   function automatic lim_type clip_limit(input logic [CSR_DATA_BITS-1:0] mult);
      logic [CSR_DATA_BITS-1:0] eff;
      eff = mult;
      if (mult < CLIP_MULT_MIN) begin
         eff = CLIP_MULT_MIN;
      end else if (mult > CLIP_MULT_MAX) begin
         eff = CLIP_MULT_MAX;
      end
      return LIM_BITS'(eff) * LIM_UNIT;
   endfunction

endpackage

>>> src/sfw_req_if.sv
// ----------------------------------------------------------------------------
// sfw_req_if: input sample channel
// Valid/ready channel that carries one raw sample per transfer.
// ----------------------------------------------------------------------------
interface sfw_req_if;
   import sfw_pkg::*;

   logic          valid;
   logic          ready;
   sample_in_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

>>> src/sfw_rsp_if.sv
// ----------------------------------------------------------------------------
// sfw_rsp_if: shaped sample channel
// Valid/ready channel that carries one shaped sample per transfer.
// ----------------------------------------------------------------------------
interface sfw_rsp_if;
   import sfw_pkg::*;

   logic           valid;
   logic           ready;
   sample_out_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

>>> src/softclip_foldback_waveshaper_top.sv
// ----------------------------------------------------------------------------
// softclip_foldback_waveshaper_top: cubic soft clipper with triangle foldback
// Clamps each sample, optionally folds it with a triangle of period 6, and
// applies y = v - (4/27)v^3 with saturation to +-1.0.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while its output is not stalled
// and returns one shaped sample for each, in order, through seven
// register stages: clamp, range reduction, fold, square, cube, divide by
// 27 through a reciprocal multiply, and subtract/saturate each own a
// stage, with the three multiplier stages setting the clock. Every stage
// has its own valid bit and advances when the stage after it is empty or
// moving, so a stalled output fills the bubbles in the pipeline before
// input is held off.
// Configuration writes take effect for samples transferred after the write.
// ----------------------------------------------------------------------------
module softclip_foldback_waveshaper_top (
   input  logic                               clock,
   input  logic                               reset,
   sfw_req_if.sink                            req_chan,
   sfw_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  sfw_pkg::csr_index_type             csr_index,
   input  logic [sfw_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);
   import sfw_pkg::*;

   localparam int STAGES = 7;

   // Configuration registers
   logic                     fold_en_ff;
   logic [CSR_DATA_BITS-1:0] clip_mult_ff;

   // Pipeline control
   logic [STAGES:1] vld_ff;
   logic [STAGES:1] vld_in;
   logic [STAGES:1] adv;

   // Stage payloads
   sample_in_type  xc1_ff,   xc1_in;
   logic           fold1_ff;
   wide_type       val2_ff,  val2_in;
   logic           fold2_ff;
   v_type          v3_ff,    v3_in;
   sq_type         sq4_ff,   sq4_in;
   v_type          v4_ff;
   mag_type        av4_ff,   av3;
   prod_type       prod5_ff, prod5_in;
   v_type          v5_ff;
   q_type          q6_ff,    q6_in;
   v_type          v6_ff;
   sample_out_type out7_ff,  out7_in;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_en_ff   <= 1'b0;
         clip_mult_ff <= CLIP_MULT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FOLD_ENABLE:   fold_en_ff   <= csr_wr_data[0];
            CSR_CLIP_MULTIPLE: clip_mult_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Advance a stage when it is empty or the next stage advances
   always_comb begin
      adv[STAGES] = !vld_ff[STAGES] || rsp_chan.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[1] = adv[1] ? req_chan.valid : vld_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready      = adv[1];
   assign rsp_chan.valid      = vld_ff[STAGES];
   assign rsp_chan.sample_out = out7_ff;

   // Stage 1: clamp to the soft-clip or foldback level
   always_comb begin
      lim_type  lim;
      wide_type xe;
      wide_type lw;
      lim = fold_en_ff ? clip_limit(clip_mult_ff) : LIM_UNIT;
      xe  = wide_type'(req_chan.sample_in);
      lw  = signed'({2'b00, lim});
      if (xe > lw) begin
         xc1_in = SAMPLE_BITS'(lw);
      end else if (xe < -lw) begin
         xc1_in = SAMPLE_BITS'(-lw);
      end else begin
         xc1_in = req_chan.sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         xc1_ff   <= xc1_in;
         fold1_ff <= fold_en_ff;
      end
   end

   // Stage 2: in foldback mode, reduce x + 3 modulo 6 (biased by 12 to stay positive)
   always_comb begin
      wide_type b;
      b = wide_type'(xc1_ff) + FOLD_BIAS;
      if (!fold1_ff) begin
         val2_in = wide_type'(xc1_ff);
      end else if (b >= FOLD_P4) begin
         val2_in = b - FOLD_P4;
      end else if (b >= FOLD_P3) begin
         val2_in = b - FOLD_P3;
      end else if (b >= FOLD_P2) begin
         val2_in = b - FOLD_P2;
      end else if (b >= FOLD_P1) begin
         val2_in = b - FOLD_P1;
      end else begin
         val2_in = b;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         val2_ff  <= val2_in;
         fold2_ff <= fold1_ff;
      end
   end

   // Stage 3: in foldback mode, triangle tail v = ||m - 4.5| - 3| - 1.5
   always_comb begin
      wide_type w;
      wide_type u;
      wide_type vv;
      w  = val2_ff - TAIL_A;
      w  = w[WIDE_BITS-1] ? -w : w;
      u  = w - TAIL_B;
      u  = u[WIDE_BITS-1] ? -u : u;
      vv = u - TAIL_C;
      v3_in = fold2_ff ? vv[V_BITS-1:0] : val2_ff[V_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         v3_ff <= v3_in;
      end
   end

   // Stage 4: square the magnitude
   always_comb begin
      v_type nv;
      nv     = -v3_ff;
      av3    = v3_ff[V_BITS-1] ? nv[MAG_BITS-1:0] : v3_ff[MAG_BITS-1:0];
      sq4_in = SQ_BITS'(av3) * SQ_BITS'(av3);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         sq4_ff <= sq4_in;
         av4_ff <= av3;
         v4_ff  <= v3_ff;
      end
   end

   // Stage 5: round v*v half up, multiply by |v|
   always_comb begin
      sq_type rnd;
      v2_type v2;
      rnd      = sq4_ff + ROUND_HALF;
      v2       = rnd[SQ_BITS-1:FRAC_BITS];
      prod5_in = PROD_BITS'(av4_ff) * PROD_BITS'(v2);
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         prod5_ff <= prod5_in;
         v5_ff    <= v4_ff;
      end
   end

   // Stage 6: q = round(4*|v|*v2 / (27 * 2^F)) through a reciprocal of 27
   always_comb begin
      nsum_type nsum;
      num_type  num;
      rp_type   rp;
      nsum  = {prod5_ff, 2'b00} + DIV_HALF;
      num   = nsum[NSUM_BITS-1:FRAC_BITS];
      rp    = RP_BITS'(num) * RP_BITS'(RECIP_27);
      q6_in = rp[RP_BITS-1:RECIP_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         q6_ff <= q6_in;
         v6_ff <= v5_ff;
      end
   end

   // Stage 7: y = v - sign(v)*q, saturate to +-1.0
   always_comb begin
      y_type ye;
      y_type qe;
      y_type y;
      ye = y_type'(v6_ff);
      qe = signed'({2'b00, q6_ff});
      y  = v6_ff[V_BITS-1] ? ye + qe : ye - qe;
      if (y > Y_ONE) begin
         out7_in = OUT_BITS'(Y_ONE);
      end else if (y < -Y_ONE) begin
         out7_in = OUT_BITS'(-Y_ONE);
      end else begin
         out7_in = y[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         out7_ff <= out7_in;
      end
   end

   // Checks
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.sample_out <= OUT_BITS'(Y_ONE)) &&
                         (rsp_chan.sample_out >= OUT_BITS'(-Y_ONE)))
      else $error("shaped sample beyond +-1.0");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (v3_ff <= V_LIMIT) && (v3_ff >= -V_LIMIT))
      else $error("folded value beyond +-1.5");

   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && fold2_ff) |-> (val2_ff >= 0) && (val2_ff < FOLD_P1))
      else $error("range reduction left the period");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[1] && !adv[2]) |=> vld_ff[1] && $stable(xc1_ff))
      else $error("stalled first stage dropped or changed its sample");

   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      (vld_ff != '1) |-> req_chan.ready)
      else $error("input held off while the pipeline has a free stage");

endmodule

>>> tb/softclip_foldback_waveshaper_top_tb.sv
// ----------------------------------------------------------------------------
// softclip_foldback_waveshaper_top_tb: self-checking bench for the waveshaper
// Drives samples through the valid/ready request channel under random gaps
// and output stalls, predicts each shaped sample in both soft-clip and
// foldback modes across several register settings, and compares every
// result transfer, in order, with the prediction.
// ----------------------------------------------------------------------------
module softclip_foldback_waveshaper_top_tb;
   import sfw_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_PERCENT = 35;

   typedef struct {
      sample_in_type  sample_in;
      sample_out_type sample_out;
   } shaped_expect_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wr_data;

   sfw_req_if req_if ();
   sfw_rsp_if rsp_if ();

   // Shadow of the block's registers
   logic                     fold_on_cfg;
   logic [CSR_DATA_BITS-1:0] clip_mult_cfg;

   shaped_expect_type expected_shapes[$];
   int                mismatch_count;
   int                cycle_count;
   bit                full_rate;

   softclip_foldback_waveshaper_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Multiple held to 1..8, as the foldback clamp uses it
   function automatic int effective_multiple(input logic [CSR_DATA_BITS-1:0] mult);
      int m;
      m = int'(mult);
      if (m < 1) m = 1;
      if (m > 8) m = 8;
      return m;
   endfunction

   // Clamp, optional triangle fold, then the cubic with saturation to +-1.0
   function automatic sample_out_type predict_shape(input sample_in_type s,
                                                    input logic fold_on,
                                                    input logic [CSR_DATA_BITS-1:0] mult);
      longint one_q, half_q, x, lim, m, v, v2, t, mag, q, y, d;
      one_q  = longint'(ONE_Q);
      half_q = longint'(HALF_ONE_Q);
      x      = longint'(s);
      lim    = fold_on ? 3 * half_q * effective_multiple(mult) : 3 * half_q;
      if (x > lim) x = lim;
      if (x < -lim) x = -lim;
      if (fold_on) begin
         m = (x + 3 * one_q) % (6 * one_q);
         if (m < 0) m += 6 * one_q;
         v = m - 3 * one_q - 3 * half_q;
         if (v < 0) v = -v;
         v -= 3 * one_q;
         if (v < 0) v = -v;
         v -= 3 * half_q;
      end else begin
         v = x;
      end
      v2  = (v * v + half_q) >>> FRAC_BITS;
      t   = 4 * v * v2;
      d   = 27 * one_q;
      mag = (t < 0) ? -t : t;
      q   = (mag + d / 2) / d;
      if (t < 0) q = -q;
      y = v - q;
      if (y > one_q) y = one_q;
      if (y < -one_q) y = -one_q;
      return sample_out_type'(y);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("ERROR: %s", what);
   endtask

   // Send one sample, with a random gap first, and record its prediction
   task automatic send_sample(input sample_in_type s);
      shaped_expect_type e;
      @(negedge clock);
      while (!full_rate && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_if.valid     <= 1'b0;
         req_if.sample_in <= sample_in_type'($urandom);
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.sample_in <= s;
      do @(posedge clock); while (!req_if.ready);
      e.sample_in  = s;
      e.sample_out = predict_shape(s, fold_on_cfg, clip_mult_cfg);
      expected_shapes.push_back(e);
   endtask

   // Drop valid after the last transfer of a stream
   task automatic end_stream();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (expected_shapes.size() != 0) @(posedge clock);
   endtask

   // Write one register; only called with nothing in flight
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      if (idx == CSR_FOLD_ENABLE) fold_on_cfg = data[0];
      else clip_mult_cfg = data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= CSR_DATA_BITS'($urandom);
   endtask

   // Drain, then set both registers for the next phase
   task automatic set_mode(input logic fold_on, input logic [CSR_DATA_BITS-1:0] mult);
      end_stream();
      wait_for_results();
      write_csr(CSR_FOLD_ENABLE, {(CSR_DATA_BITS-1)'($urandom), fold_on});
      write_csr(CSR_CLIP_MULTIPLE, mult);
   endtask

   // Random samples: mostly inside the clamp range, some near fold points,
   // some at the clamp edges and some over the whole input range
   task automatic run_random_batch(input int count);
      sample_in_type s;
      longint        lim, span;
      int            k;
      for (int i = 0; i < count; i++) begin
         lim  = fold_on_cfg ? 393216 * effective_multiple(clip_mult_cfg) : 393216;
         span = lim + lim / 8;
         case ($urandom_range(0, 9))
            0, 1: s = sample_in_type'($urandom);
            2: begin
               case ($urandom_range(0, 6))
                  0: s = sample_in_type'(8388607);
                  1: s = sample_in_type'(-8388608);
                  2: s = sample_in_type'(lim);
                  3: s = sample_in_type'(-lim);
                  4: s = sample_in_type'(lim + 1);
                  5: s = sample_in_type'(-lim - 1);
                  default: s = '0;
               endcase
            end
            3: begin
               k = int'($urandom_range(0, 16)) - 8;
               s = sample_in_type'(k * 393216 + int'($urandom_range(0, 6)) - 3);
            end
            default: s = sample_in_type'(longint'($urandom_range(0, 32'(2 * span))) - span);
         endcase
         send_sample(s);
      end
   endtask

   // Stall the result side at random and check each result transfer
   always @(negedge clock) begin
      rsp_if.ready <= full_rate || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      shaped_expect_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_shapes.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_if.sample_out));
         end else begin
            e = expected_shapes.pop_front();
            if (rsp_if.sample_out !== e.sample_out) begin
               report_mismatch($sformatf("sample_in %0d: sample_out %0d, predicted %0d",
                                         e.sample_in, rsp_if.sample_out, e.sample_out));
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL softclip_foldback_waveshaper_top");
         $finish;
      end
   end

   // Soft clip with the reset register values
   task automatic test_reset_defaults();
      sample_in_type pts[3] = '{0, 393216, -8388608};
      foreach (pts[i]) send_sample(pts[i]);
   endtask

   // Soft clip at the clamp edges and the input maximum; multiple is ignored
   task automatic test_soft_clip_directed();
      sample_in_type pts[8] = '{8388607, 393217, -393217, 262144, -262144, 1, -1, 131072};
      set_mode(1'b0, 4'd5);
      foreach (pts[i]) send_sample(pts[i]);
   endtask

   // Foldback with multiple zero, above eight, and at fold ties
   task automatic test_foldback_directed();
      sample_in_type zero_pts[3]  = '{786432, -786432, 8388607};
      sample_in_type wide_pts[8]  = '{3145728, 3145729, -3145729, 1179648, -1179648,
                                      786432, 2359296, -8388608};
      set_mode(1'b1, 4'd0);
      foreach (zero_pts[i]) send_sample(zero_pts[i]);
      set_mode(1'b1, 4'd15);
      foreach (wide_pts[i]) send_sample(wide_pts[i]);
      set_mode(1'b1, 4'd9);
      send_sample(sample_in_type'(8388607));
   endtask

   // Random samples across a sweep of register settings
   task automatic test_random_sweep();
      set_mode(1'b0, CSR_DATA_BITS'($urandom));
      run_random_batch(150);
      set_mode(1'b1, 4'd1);
      run_random_batch(150);
      set_mode(1'b1, 4'd8);
      run_random_batch(150);
      set_mode(1'b1, 4'd0);
      run_random_batch(150);
      set_mode(1'b1, 4'd15);
      run_random_batch(150);
      for (int p = 0; p < 4; p++) begin
         set_mode(1'($urandom), CSR_DATA_BITS'($urandom));
         run_random_batch(150);
      end
   endtask

   // Full rate on both sides
   task automatic test_back_to_back();
      set_mode(1'b1, CSR_DATA_BITS'($urandom_range(2, 7)));
      full_rate = 1'b1;
      run_random_batch(250);
      end_stream();
      wait_for_results();
      full_rate = 1'b0;
   endtask

   // Pause the sender until every result is back, then resume
   task automatic test_drain_pause();
      set_mode(1'b0, CSR_DATA_BITS'($urandom));
      run_random_batch(125);
      end_stream();
      wait_for_results();
      run_random_batch(125);
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_FOLD_ENABLE;
      csr_wr_data      = '0;
      req_if.valid     = 1'b0;
      req_if.sample_in = '0;
      rsp_if.ready     = 1'b0;
      fold_on_cfg      = 1'b0;
      clip_mult_cfg    = CLIP_MULT_RESET;
      mismatch_count   = 0;
      cycle_count      = 0;
      full_rate        = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_soft_clip_directed();
      test_foldback_directed();
      test_random_sweep();
      test_back_to_back();
      test_drain_pause();

      // Drain and let the pipeline run dry
      end_stream();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS softclip_foldback_waveshaper_top");
      end else begin
         $display("FAIL softclip_foldback_waveshaper_top");
      end
      $finish;
   end

endmodule
